// ===== sv/vqfl_pkg.sv =====
// Shared types and constants of the frame labeler.
`timescale 1ns / 1ps

package vqfl_pkg;

    // Fixed field widths of the stream and configuration beats.
    localparam int VALUE_W     = 16;
    localparam int UNIT_IDX_W  = 6;
    localparam int ELEM_IDX_W  = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Bit positions inside s_tdata and s_tuser.
    localparam int UNIT_LSB    = 0;
    localparam int ELEM_LSB    = UNIT_LSB + UNIT_IDX_W;
    localparam int VALUE_LSB   = ELEM_LSB + ELEM_IDX_W;
    localparam int USER_CMD    = 0;
    localparam int USER_SILENT = 1;
    localparam int USER_CLIP   = 2;

    // Input command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ENABLE = 2'd2;

    localparam logic [7:0] FEATURE_LEN_RST = 8'd120;
    localparam logic [6:0] UNIT_COUNT_RST  = 7'd64;
    localparam logic       SMOOTH_RST      = 1'b1;

    // Element counter saturates here; at most 128 elements are summed,
    // so 128 * 65535^2 fits in 40 bits.
    localparam int          CNT_W   = 7;
    localparam logic [6:0]  CNT_MAX = 7'd127;
    localparam int          ACC_W   = 40;

    // Drain count at which the last accumulate write has landed.
    localparam logic [1:0]  DRAIN_LAST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ACCUM,
        ST_DRAIN,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_EMIT_MID,
        ST_EMIT_LAST
    } state_t;

    typedef struct packed {
        logic accept;
        logic k_clear;
        logic k_step;
        logic acc_issue;
        logic scan_issue;
        logic frame_done;
        logic push_mid;
        logic push_last;
        logic label_update;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic do_accum;
        logic is_last;
        logic clip_end;
        logic k_last;
        logic units_zero;
        logic fs_zero;
        logic fifo_full;
    } status_t;

endpackage

// ===== sv/vq_frame_labeler_unit.sv =====
// Top level of the nearest-centroid frame labeler.
// A frame element is accumulated against each centroid in use, one per cycle; a closing
// element then scans their distances and may wait for room in the two-beat output queue.
// Labels leave one frame late, but the last label of a clip leaves with its own frame.
// Reset (rst_n, asynchronous) clears control, label track and distances and restores the
// registers to 120, 64 and 1; centroid memory is not cleared.
`timescale 1ns / 1ps

module vq_frame_labeler_unit #(
    parameter int MAX_UNITS    = 64,
    parameter int MAX_DIM      = 128,
    localparam int LABEL_W     = $clog2(MAX_UNITS + 1),
    localparam int OUT_TDATA_W = ((LABEL_W + 7) / 8) * 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [vqfl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vqfl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // unit_index[5:0], element_index[12:6], value[28:13], zero[31:29]
    input  logic [vqfl_pkg::IN_TDATA_W-1:0]       s_tdata,
    // cmd[0], frame_silent[1], clip_end[2]
    input  logic [vqfl_pkg::IN_TUSER_W-1:0]       s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // label[LABEL_W-1:0], zero above
    output logic [OUT_TDATA_W-1:0]                m_tdata,
    output logic                                  m_tlast
);

    vqfl_pkg::cmd_t     cmd;
    vqfl_pkg::status_t  status;
    logic [LABEL_W-1:0] label;

    vqfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .ready    (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    vqfl_datapath #(
        .MAX_UNITS (MAX_UNITS),
        .MAX_DIM   (MAX_DIM)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .label     (label),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    assign m_tdata = OUT_TDATA_W'(label);

    // A result is only pushed when the output queue has room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_mid || cmd.push_last) |-> !status.fifo_full)
        else $error("result pushed into a full output queue");

    // Ready is low in the cycle after a beat is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready held high right after an accepted beat");

    // Accumulation is only issued when some centroid is in use.
    a_accum_units: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_issue |-> !status.units_zero)
        else $error("accumulate issued with no centroid in use");

endmodule

// ===== sv/vqfl_ctrl.sv =====
// Controller state machine that sequences accumulation, scan and label output.
`timescale 1ns / 1ps

module vqfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              ready,
    output vqfl_pkg::cmd_t    cmd,
    input  vqfl_pkg::status_t status
);

    vqfl_pkg::state_t state_reg;
    vqfl_pkg::state_t state_next;
    logic [1:0]       drain_reg;
    logic [1:0]       drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vqfl_pkg::ST_IDLE;
            drain_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        drain_next = (state_reg == vqfl_pkg::ST_DRAIN) ? drain_reg + 2'd1 : 2'd0;
        unique case (state_reg)
            vqfl_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept  = 1'b1;
                    cmd.k_clear = 1'b1;
                    state_next  = vqfl_pkg::ST_DECIDE;
                end
            end
            vqfl_pkg::ST_DECIDE:
            begin
                priority if (status.is_load)
                    state_next = vqfl_pkg::ST_IDLE;
                else if (status.do_accum)
                    state_next = vqfl_pkg::ST_ACCUM;
                else if (status.is_last)
                begin
                    cmd.k_clear = 1'b1;
                    state_next  = vqfl_pkg::ST_SCAN;
                end
                else
                    state_next = vqfl_pkg::ST_IDLE;
            end
            vqfl_pkg::ST_ACCUM:
            begin
                cmd.acc_issue = 1'b1;
                cmd.k_step    = 1'b1;
                if (status.k_last)
                    state_next = vqfl_pkg::ST_DRAIN;
            end
            vqfl_pkg::ST_DRAIN:
            begin
                if (drain_reg == vqfl_pkg::DRAIN_LAST)
                begin
                    if (status.is_last)
                    begin
                        cmd.k_clear = 1'b1;
                        state_next  = vqfl_pkg::ST_SCAN;
                    end
                    else
                        state_next = vqfl_pkg::ST_IDLE;
                end
            end
            vqfl_pkg::ST_SCAN:
            begin
                if (status.units_zero)
                    state_next = vqfl_pkg::ST_SCAN_WAIT;
                else
                begin
                    cmd.scan_issue = 1'b1;
                    cmd.k_step     = 1'b1;
                    if (status.k_last)
                        state_next = vqfl_pkg::ST_SCAN_WAIT;
                end
            end
            vqfl_pkg::ST_SCAN_WAIT:
            begin
                cmd.frame_done = 1'b1;
                state_next     = vqfl_pkg::ST_EMIT_MID;
            end
            vqfl_pkg::ST_EMIT_MID:
            begin
                // The first frame of a clip has no pending label yet.
                if (status.fs_zero)
                    state_next = vqfl_pkg::ST_EMIT_LAST;
                else if (!status.fifo_full)
                begin
                    cmd.push_mid = 1'b1;
                    state_next   = vqfl_pkg::ST_EMIT_LAST;
                end
            end
            vqfl_pkg::ST_EMIT_LAST:
            begin
                if (!status.clip_end)
                begin
                    cmd.label_update = 1'b1;
                    state_next       = vqfl_pkg::ST_IDLE;
                end
                else if (!status.fifo_full)
                begin
                    cmd.push_last    = 1'b1;
                    cmd.label_update = 1'b1;
                    state_next       = vqfl_pkg::ST_IDLE;
                end
            end
            default:
                state_next = vqfl_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== sv/vqfl_datapath.sv =====
// Datapath: configuration, centroid and distance memories, distance pipeline,
// nearest search, label track and output queue.
`timescale 1ns / 1ps

module vqfl_datapath #(
    parameter int MAX_UNITS = 64,
    parameter int MAX_DIM   = 128,
    localparam int LABEL_W  = $clog2(MAX_UNITS + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vqfl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vqfl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [vqfl_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [vqfl_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [LABEL_W-1:0]                   label,
    output logic                                 m_tlast,
    input  vqfl_pkg::cmd_t                       cmd,
    output vqfl_pkg::status_t                    status
);

    localparam int UIW = $clog2(MAX_UNITS);
    localparam int UCW = $clog2(MAX_UNITS + 1);
    localparam int EW  = $clog2(MAX_DIM);
    localparam int CAW = $clog2(MAX_UNITS * MAX_DIM);
    localparam int VW  = vqfl_pkg::VALUE_W;
    localparam int AW  = vqfl_pkg::ACC_W;

    // Configuration registers.
    logic [7:0] feature_len_reg;
    logic [6:0] unit_count_reg;
    logic       smooth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_len_reg <= vqfl_pkg::FEATURE_LEN_RST;
            unit_count_reg  <= vqfl_pkg::UNIT_COUNT_RST;
            smooth_reg      <= vqfl_pkg::SMOOTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vqfl_pkg::CFG_FEATURE_LEN:   feature_len_reg <= cfg_data;
                vqfl_pkg::CFG_UNIT_COUNT:    unit_count_reg  <= cfg_data[6:0];
                vqfl_pkg::CFG_SMOOTH_ENABLE: smooth_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input beat fields.
    logic [vqfl_pkg::UNIT_IDX_W-1:0] unit_in;
    logic [vqfl_pkg::ELEM_IDX_W-1:0] elem_in;
    logic [VW-1:0]                   value_in;
    logic                            is_load_in;

    assign unit_in    = s_tdata[vqfl_pkg::UNIT_LSB +: vqfl_pkg::UNIT_IDX_W];
    assign elem_in    = s_tdata[vqfl_pkg::ELEM_LSB +: vqfl_pkg::ELEM_IDX_W];
    assign value_in   = s_tdata[vqfl_pkg::VALUE_LSB +: VW];
    assign is_load_in = (s_tuser[vqfl_pkg::USER_CMD] == vqfl_pkg::CMD_LOAD);

    logic [31:0]    flen;
    logic [UCW-1:0] units_in;
    logic           do_accum_in;
    logic           store_we;
    logic [CAW-1:0] store_waddr;

    assign flen     = (32'(feature_len_reg) < MAX_DIM) ? 32'(feature_len_reg) : MAX_DIM;
    assign units_in = (32'(unit_count_reg) < MAX_UNITS) ? UCW'(unit_count_reg)
                                                        : UCW'(MAX_UNITS);

    logic [vqfl_pkg::CNT_W-1:0] ec_reg;
    logic                       full_reg;

    assign do_accum_in = !full_reg && (32'(ec_reg) < flen) && (units_in != '0);
    assign store_we    = cmd.accept && is_load_in && (32'(unit_in) < MAX_UNITS)
                         && (32'(elem_in) < MAX_DIM);
    assign store_waddr = CAW'(32'(unit_in) * MAX_DIM + 32'(elem_in));

    // Latched item.
    logic [VW-1:0]  value_reg;
    logic           silent_reg;
    logic           last_reg;
    logic           clip_reg;
    logic           is_load_reg;
    logic           do_accum_reg;
    logic [EW-1:0]  elem_reg;
    logic [UCW-1:0] units_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_load_reg  <= 1'b0;
            do_accum_reg <= 1'b0;
            last_reg     <= 1'b0;
            clip_reg     <= 1'b0;
            units_reg    <= '0;
            ec_reg       <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                is_load_reg  <= is_load_in;
                do_accum_reg <= !is_load_in && do_accum_in;
                last_reg     <= !is_load_in && s_tlast;
                clip_reg     <= s_tuser[vqfl_pkg::USER_CLIP];
                units_reg    <= units_in;
                if (!is_load_in)
                begin
                    if (ec_reg >= vqfl_pkg::CNT_MAX)
                        full_reg <= 1'b1;
                    else
                        ec_reg <= ec_reg + 1'b1;
                end
            end
            if (cmd.frame_done)
            begin
                ec_reg   <= '0;
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            value_reg  <= value_in;
            silent_reg <= s_tuser[vqfl_pkg::USER_SILENT];
            // Only used when the element is in range, so the cut is safe.
            elem_reg   <= EW'(ec_reg);
        end
    end

    // Centroid counter shared by accumulate and scan passes.
    logic [UIW-1:0] k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= '0;
        else if (cmd.k_clear)
            k_reg <= '0;
        else if (cmd.k_step)
            k_reg <= k_reg + 1'b1;
    end

    // Centroid memory.
    logic [VW-1:0]  cent_mem [MAX_UNITS * MAX_DIM];
    logic [VW-1:0]  cent_q;
    logic [CAW-1:0] cent_raddr;

    assign cent_raddr = CAW'(32'(k_reg) * MAX_DIM + 32'(elem_reg));

    always_ff @(posedge clk)
    begin
        if (store_we)
            cent_mem[store_waddr] <= value_in;
        cent_q <= cent_mem[cent_raddr];
    end

    // Distance pipeline: read, magnitude, square, accumulate.
    logic           p1_v_reg, p2_v_reg, p3_v_reg;
    logic [UIW-1:0] p1_k_reg, p2_k_reg, p3_k_reg;
    logic [VW-1:0]  mag_reg;
    logic [2*VW-1:0] sq_reg;
    logic [VW:0]    diff;
    logic [VW:0]    diff_abs;

    assign diff     = {value_reg[VW-1], value_reg} - {cent_q[VW-1], cent_q};
    assign diff_abs = diff[VW] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end
        else
        begin
            p1_v_reg <= cmd.acc_issue;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_k_reg <= k_reg;
        p2_k_reg <= p1_k_reg;
        p3_k_reg <= p2_k_reg;
        mag_reg  <= diff_abs[VW-1:0];
        sq_reg   <= mag_reg * mag_reg;
    end

    // Distance memory with a valid bit per centroid; an invalid entry reads zero.
    logic [AW-1:0]        acc_mem [MAX_UNITS];
    logic [MAX_UNITS-1:0] acc_vld_reg;
    logic [AW-1:0]        acc_q;
    logic                 acc_vld_q;
    logic [AW-1:0]        acc_eff;
    logic [UIW-1:0]       acc_raddr;

    assign acc_raddr = cmd.scan_issue ? k_reg : p2_k_reg;
    assign acc_eff   = acc_vld_q ? acc_q : '0;

    always_ff @(posedge clk)
    begin
        if (p3_v_reg)
            acc_mem[p3_k_reg] <= acc_eff + AW'(sq_reg);
        acc_q     <= acc_mem[acc_raddr];
        acc_vld_q <= acc_vld_reg[acc_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_vld_reg <= '0;
        else if (cmd.frame_done)
            acc_vld_reg <= '0;
        else if (p3_v_reg)
            acc_vld_reg[p3_k_reg] <= 1'b1;
    end

    // Nearest search; strict less-than keeps the lowest index on a tie.
    logic           s_v_reg;
    logic [UIW-1:0] s_k_reg;
    logic [AW-1:0]  best_val_reg;
    logic [UIW-1:0] best_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_v_reg      <= 1'b0;
            best_idx_reg <= '0;
        end
        else
        begin
            s_v_reg <= cmd.scan_issue;
            if (cmd.k_clear)
                best_idx_reg <= '0;
            else if (s_v_reg && ((s_k_reg == '0) || (acc_eff < best_val_reg)))
                best_idx_reg <= s_k_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s_k_reg <= k_reg;
        if (s_v_reg && ((s_k_reg == '0) || (acc_eff < best_val_reg)))
            best_val_reg <= acc_eff;
    end

    // Label track and smoothing.
    logic [1:0]         fs_reg;
    logic [LABEL_W-1:0] prev_reg;
    logic [LABEL_W-1:0] prev2_reg;
    logic [LABEL_W-1:0] raw;
    logic [LABEL_W-1:0] mid;

    assign raw = silent_reg ? '0 : LABEL_W'(best_idx_reg) + LABEL_W'(1);
    assign mid = (fs_reg[1] && smooth_reg && (prev2_reg == raw) && (prev2_reg != prev_reg))
                 ? prev2_reg : prev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg    <= 2'd0;
            prev_reg  <= '0;
            prev2_reg <= '0;
        end
        else if (cmd.label_update)
        begin
            if (clip_reg)
            begin
                fs_reg    <= 2'd0;
                prev_reg  <= '0;
                prev2_reg <= '0;
            end
            else
            begin
                prev2_reg <= prev_reg;
                prev_reg  <= raw;
                if (!fs_reg[1])
                    fs_reg <= fs_reg + 2'd1;
            end
        end
    end

    // Two-beat output queue.
    logic [LABEL_W-1:0] q_label_reg [2];
    logic               q_last_reg  [2];
    logic               head_reg;
    logic [1:0]         count_reg;
    logic               push;
    logic               pop;
    logic               tail;

    assign push = cmd.push_mid || cmd.push_last;
    assign pop  = m_tvalid && m_tready;
    assign tail = head_reg ^ count_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (pop)
                head_reg <= ~head_reg;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_label_reg[tail] <= cmd.push_last ? raw : mid;
            q_last_reg[tail]  <= cmd.push_last;
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign label    = q_label_reg[head_reg];
    assign m_tlast  = q_last_reg[head_reg];

    assign status.is_load    = is_load_reg;
    assign status.do_accum   = do_accum_reg;
    assign status.is_last    = last_reg;
    assign status.clip_end   = clip_reg;
    assign status.k_last     = (32'(k_reg) + 32'd1) >= 32'(units_reg);
    assign status.units_zero = (units_reg == '0);
    assign status.fs_zero    = (fs_reg == 2'd0);
    assign status.fifo_full  = (count_reg == 2'd2);

endmodule
